[hw/rtl/cfgrc_pkg.sv]
package cfgrc_pkg;

  // Record layout: covered bytes, then a 4-byte stored CRC
  localparam int unsigned COVERED_BYTES = 38;
  localparam int unsigned POS_W         = 6;

  localparam logic [POS_W-1:0] MAGIC_LAST_POS   = POS_W'(3);
  localparam logic [POS_W-1:0] VERSION_LAST_POS = POS_W'(7);
  localparam logic [POS_W-1:0] CRC_END_POS      = POS_W'(COVERED_BYTES);
  localparam logic [POS_W-1:0] RECORD_LAST_POS  = POS_W'(COVERED_BYTES + 3);

  // CRC-32, reflected form
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Register reset values
  localparam logic [31:0] MAGIC_RESET   = 32'h4C53_4347;
  localparam logic [31:0] VERSION_RESET = 32'h0000_0001;

  // Register indexes
  typedef enum logic {
    REG_EXPECTED_MAGIC   = 1'b0,
    REG_EXPECTED_VERSION = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_MAGIC   = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_BAD_CRC     = 2'd3
  } check_status_e;

  typedef struct packed {
    logic [7:0] record_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    check_status_e check_status;
    logic [31:0]   computed_crc;
  } out_item_t;

  // One byte through the reflected CRC: eight shift/XOR levels
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[hw/rtl/config_record_checker_core.sv]
// Settings record checker.
// Input channel (in_valid_i/in_ready_o, in_item_i): one record byte per item,
// first_byte restarts the record. A record is COVERED_BYTES bytes covered by a
// reflected CRC-32 followed by the 4-byte stored CRC (little-endian).
// Output channel (out_valid_o/out_ready_i, out_item_o): one item per record,
// issued for its last byte, with the status and the computed CRC.
// Configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_idx_i
// (0 expected magic, 1 expected version); write only while idle.
// Throughput: one byte per cycle unless the output stalls; the CRC update of a
// byte is combinational logic between the record state registers and the output register.
// Latency: the result is valid the cycle after the last byte is accepted.
// Stall: the output register holds its item until taken; while it is full
// and not being taken, in_ready_o is low, otherwise bytes keep flowing.
// Reset: registers return to their reset values, the output is empty and
// the next byte is taken as byte 0 of a record.
module config_record_checker_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cfgrc_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cfgrc_pkg::out_item_t  out_item_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [31:0]           cfg_wdata_i
);

  logic [31:0] exp_magic_q, exp_version_q;

  logic [cfgrc_pkg::POS_W-1:0] pos_q, pos_d, pos_cur;
  logic [31:0] crc_q, crc_d, crc_base;
  logic [31:0] word_q, word_d, word_base;
  logic        magic_mm_q, magic_mm_d, mm_magic_base;
  logic        version_mm_q, version_mm_d, mm_version_base;

  logic                 out_valid_q;
  cfgrc_pkg::out_item_t out_item_q, out_item_d;

  logic in_acc, out_take, last_byte;
  logic [31:0] final_crc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_magic_q   <= cfgrc_pkg::MAGIC_RESET;
      exp_version_q <= cfgrc_pkg::VERSION_RESET;
    end else if (cfg_we_i) begin
      case (cfgrc_pkg::reg_idx_e'(cfg_idx_i))
        cfgrc_pkg::REG_EXPECTED_MAGIC:   exp_magic_q   <= cfg_wdata_i;
        cfgrc_pkg::REG_EXPECTED_VERSION: exp_version_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Per-byte record update
  always_comb begin
    // first mark drops any partial record
    pos_cur         = in_item_i.first_byte ? '0 : pos_q;
    crc_base        = in_item_i.first_byte ? cfgrc_pkg::CRC_INIT : crc_q;
    word_base       = in_item_i.first_byte ? '0 : word_q;
    mm_magic_base   = in_item_i.first_byte ? 1'b0 : magic_mm_q;
    mm_version_base = in_item_i.first_byte ? 1'b0 : version_mm_q;

    word_d = {in_item_i.record_byte, word_base[31:8]};
    crc_d  = (pos_cur < cfgrc_pkg::CRC_END_POS)
             ? cfgrc_pkg::crc_byte(crc_base, in_item_i.record_byte) : crc_base;
    magic_mm_d   = (pos_cur == cfgrc_pkg::MAGIC_LAST_POS)
                   ? (word_d != exp_magic_q) : mm_magic_base;
    version_mm_d = (pos_cur == cfgrc_pkg::VERSION_LAST_POS)
                   ? (word_d != exp_version_q) : mm_version_base;
    last_byte = (pos_cur == cfgrc_pkg::RECORD_LAST_POS);
    pos_d     = pos_cur + cfgrc_pkg::POS_W'(1);

    // result for the last byte
    final_crc = ~crc_d;
    out_item_d.computed_crc = final_crc;
    if (magic_mm_d) begin
      out_item_d.check_status = cfgrc_pkg::ST_BAD_MAGIC;
    end else if (version_mm_d) begin
      out_item_d.check_status = cfgrc_pkg::ST_BAD_VERSION;
    end else if (word_d != final_crc) begin
      out_item_d.check_status = cfgrc_pkg::ST_BAD_CRC;
    end else begin
      out_item_d.check_status = cfgrc_pkg::ST_OK;
    end
  end

  // Record state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      crc_q        <= cfgrc_pkg::CRC_INIT;
      word_q       <= '0;
      magic_mm_q   <= 1'b0;
      version_mm_q <= 1'b0;
    end else if (in_acc) begin
      if (last_byte) begin
        pos_q        <= '0;
        crc_q        <= cfgrc_pkg::CRC_INIT;
        word_q       <= '0;
        magic_mm_q   <= 1'b0;
        version_mm_q <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        crc_q        <= crc_d;
        word_q       <= word_d;
        magic_mm_q   <= magic_mm_d;
        version_mm_q <= version_mm_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_byte) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[sim/record_verdict_checker.sv]
`timescale 1ns / 100ps

package cfgrc_tb_pkg;

  localparam int unsigned RECORD_BYTES = cfgrc_pkg::COVERED_BYTES + 4;

  // Reflected CRC-32, fed one data bit at a time, LSB first
  function automatic logic [31:0] crc32_feed(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = c >> 1;
      if (fb) c = c ^ cfgrc_pkg::CRC_POLY;
    end
    return c;
  endfunction

endpackage

// Watches both channels and the register port, predicts each record verdict
// and compares the block's results against it in order.
module record_verdict_checker
  import cfgrc_pkg::*;
  import cfgrc_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output int          mismatch_count_o,
  output int          verdicts_due_o
);

  // Register copies
  logic [31:0]      magic_cfg;
  logic [31:0]      version_cfg;

  // Record state
  logic [POS_W-1:0] rec_pos;
  logic [31:0]      crc_acc;
  logic [31:0]      last_word;
  logic             magic_bad;
  logic             version_bad;

  // Verdicts predicted but not yet seen on the output
  out_item_t        verdict_q[$];

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  task automatic fresh_record();
    rec_pos     = '0;
    crc_acc     = CRC_INIT;
    last_word   = '0;
    magic_bad   = 1'b0;
    version_bad = 1'b0;
  endtask

  // One record byte; the last byte of a record yields a verdict
  task automatic predict_byte(input in_item_t it);
    logic [POS_W-1:0] pos;
    out_item_t        v;
    if (it.first_byte) fresh_record();
    pos       = rec_pos;
    last_word = {it.record_byte, last_word[31:8]};
    if (pos < CRC_END_POS) crc_acc = crc32_feed(crc_acc, it.record_byte);
    if (pos == MAGIC_LAST_POS) magic_bad = (last_word != magic_cfg);
    if (pos == VERSION_LAST_POS) version_bad = (last_word != version_cfg);
    if (pos == RECORD_LAST_POS) begin
      v.computed_crc = ~crc_acc;
      if (magic_bad) begin
        v.check_status = ST_BAD_MAGIC;
      end else if (version_bad) begin
        v.check_status = ST_BAD_VERSION;
      end else if (last_word != v.computed_crc) begin
        v.check_status = ST_BAD_CRC;
      end else begin
        v.check_status = ST_OK;
      end
      verdict_q.push_back(v);
      fresh_record();
    end else begin
      rec_pos = pos + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track_items
    out_item_t want;
    if (!rst_ni) begin
      magic_cfg   = MAGIC_RESET;
      version_cfg = VERSION_RESET;
      fresh_record();
      verdict_q.delete();
    end else begin
      // Output first: a byte taken at this edge gives its verdict later
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch("unexpected result crc", out_item_i.computed_crc, '0);
        end else begin
          want = verdict_q.pop_front();
          if (out_item_i.check_status !== want.check_status)
            flag_mismatch("check_status", 32'(out_item_i.check_status),
                          32'(want.check_status));
          if (out_item_i.computed_crc !== want.computed_crc)
            flag_mismatch("computed_crc", out_item_i.computed_crc, want.computed_crc);
        end
      end
      if (in_valid_i && in_ready_i) predict_byte(in_item_i);
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_EXPECTED_MAGIC:   magic_cfg = cfg_wdata_i;
          REG_EXPECTED_VERSION: version_cfg = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    verdicts_due_o = verdict_q.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import cfgrc_pkg::*;
  import cfgrc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_item_t    in_item_i   = '0;
  logic        out_ready_i = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  out_item_t   out_item_o;

  int          mismatches;
  int          verdicts_due;
  int          idle_pct    = 12;
  int          cycle_count = 0;
  logic [31:0] cur_magic   = MAGIC_RESET;
  logic [31:0] cur_version = VERSION_RESET;
  bit          in_step     = 1'b1;  // block known to sit at byte 0

  config_record_checker_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  record_verdict_checker u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_item_i        (in_item_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_item_i       (out_item_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatches),
    .verdicts_due_o   (verdicts_due)
  );

  always #5 clk_i = ~clk_i;

  // Result side stalls at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** config_record_checker_core: FAILED **");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b, input bit f);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{record_byte: b, first_byte: f};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Hold the sender until every verdict has come
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (verdicts_due != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] m, input logic [31:0] v);
    wait_drained();
    cfg_write(REG_EXPECTED_MAGIC, m);
    cfg_write(REG_EXPECTED_VERSION, v);
    cur_magic   = m;
    cur_version = v;
  endtask

  // Builds a record; crc_flip corrupts the stored CRC, fill < 0 means random
  // body, cut is the number of bytes actually sent
  task automatic send_record(input logic [31:0] magic, input logic [31:0] version,
                             input logic [31:0] crc_flip, input bit mark,
                             input int fill, input int cut);
    logic [7:0]  rec [RECORD_BYTES];
    logic [31:0] crc;
    for (int i = 0; i < 4; i++) begin
      rec[i]     = magic[8*i +: 8];
      rec[4 + i] = version[8*i +: 8];
    end
    for (int i = 8; i < COVERED_BYTES; i++) begin
      rec[i] = (fill < 0) ? 8'($urandom) : fill[7:0];
    end
    crc = CRC_INIT;
    for (int i = 0; i < COVERED_BYTES; i++) begin
      crc = crc32_feed(crc, rec[i]);
    end
    crc = ~crc ^ crc_flip;
    for (int i = 0; i < 4; i++) begin
      rec[COVERED_BYTES + i] = crc[8*i +: 8];
    end
    for (int i = 0; i < cut; i++) begin
      put_byte(rec[i], (i == 0) && mark);
    end
    in_step = (cut == RECORD_BYTES);
  endtask

  function automatic logic [31:0] flip_mask();
    if ($urandom_range(1)) return 32'd1 << $urandom_range(31);
    return $urandom | 32'd1;
  endfunction

  // Mostly well-formed records, some corrupted, cut short, or plain noise
  task automatic random_record();
    int          kind;
    int          n;
    logic [31:0] m;
    logic [31:0] v;
    logic [31:0] flip;
    bit          mark;
    kind = $urandom_range(99);
    m    = cur_magic;
    v    = cur_version;
    flip = '0;
    mark = in_step ? 1'($urandom) : 1'b1;
    if (kind < 93) begin
      if (kind >= 60 && kind < 68) m = cur_magic ^ flip_mask();
      else if (kind >= 68 && kind < 76) v = cur_version ^ flip_mask();
      else if (kind >= 76 && kind < 86) flip = flip_mask();
      send_record(m, v, flip, mark, -1,
                  (kind >= 86) ? $urandom_range(1, RECORD_BYTES - 1) : RECORD_BYTES);
    end else begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        put_byte(8'($urandom), $urandom_range(3) == 0);
      end
      in_step = 1'b0;
    end
  endtask

  task automatic run_random(input int records);
    for (int r = 0; r < records; r++) begin
      if ($urandom_range(9) == 0) wait_drained();
      random_record();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unmarked record straight after reset, unmarked follow-on,
    // body extremes, each status, all fields wrong, restart in mid-record
    send_record(MAGIC_RESET, VERSION_RESET, '0, 1'b0, -1, RECORD_BYTES);
    send_record(MAGIC_RESET, VERSION_RESET, '0, 1'b0, 8'hFF, RECORD_BYTES);
    send_record(MAGIC_RESET, VERSION_RESET, '0, 1'b1, 8'h00, RECORD_BYTES);
    send_record(MAGIC_RESET ^ 32'h8000_0000, VERSION_RESET, '0, 1'b1, -1, RECORD_BYTES);
    send_record(MAGIC_RESET, VERSION_RESET ^ 32'd1, '0, 1'b1, -1, RECORD_BYTES);
    send_record(MAGIC_RESET, VERSION_RESET, 32'h0000_0001, 1'b1, -1, RECORD_BYTES);
    send_record(~MAGIC_RESET, ~VERSION_RESET, 32'hFFFF_FFFF, 1'b1, -1, RECORD_BYTES);
    send_record(MAGIC_RESET, VERSION_RESET, '0, 1'b1, -1, 20);
    send_record(MAGIC_RESET, VERSION_RESET, '0, 1'b1, -1, RECORD_BYTES);

    // Random phases over several register settings
    set_config(32'h0000_0000, 32'h0000_0000);
    run_random(5);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    idle_pct = 0;
    run_random(6);
    idle_pct = 12;
    set_config($urandom, $urandom);
    run_random(5);
    set_config($urandom, $urandom_range(0, 255));
    run_random(5);
    set_config(MAGIC_RESET, VERSION_RESET);
    run_random(5);

    wait_drained();
    if (mismatches == 0) begin
      $display("** config_record_checker_core: PASSED **");
    end else begin
      $display("** config_record_checker_core: FAILED **");
    end
    $finish;
  end

endmodule
